// ----- hw/rtl/tro_pkg.sv -----
// Shared types and constants of the torus relative offset block.
package tro_pkg;

    localparam int NODE_W        = 21;
    localparam int SIZE_W        = 7;
    localparam int OFS_W         = 8;
    localparam int MAX_DIM       = 127;
    localparam int DIRECTION_BIT = 7;
    localparam int DIV_BPS       = 3;
    localparam int LANES         = 2;
    localparam int LANE_DST      = 0;
    localparam int LANE_SRC      = 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd4;

    typedef struct packed {
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] destination_node;
    } t_tro_in;

    typedef struct packed {
        logic [OFS_W-1:0] rel_x;
        logic [OFS_W-1:0] rel_y;
        logic [OFS_W-1:0] rel_z;
        logic             id_error;
    } t_tro_out;

endpackage

// ----- hw/rtl/torus3d_relative_offset.sv -----
// Top level of the 3D torus relative offset block.
//
// The block takes a source and a destination node number of a 3D torus and
// returns, per dimension, the hop count along the shorter way around with
// bit 7 set when that way is negative (west, north, down); a tie at half
// the size stays positive. Node numbers run x fastest, then y, then z. A
// node number at or beyond x_size * y_size * z_size sets id_error and
// clears the three offsets. Sizes of zero act as one. The block accepts one
// transaction every cycle while its output is not held, and returns results
// in order. The node number is divided by x_size in one pipelined restoring
// divider with three quotient bits per stage by default, the quotient by
// y_size in a second one, and a last register stage forms the offsets and
// the range check. The range check needs no multiplier: a node lies outside
// the grid exactly when the second quotient reaches z_size. The whole
// pipeline advances together; it halts only while a finished result sits
// in the output register and the consumer stalls. Size registers may only be
// written while no transaction is in flight.
module torus3d_relative_offset #(
    parameter int DIV_BPS = tro_pkg::DIV_BPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tro_pkg::t_tro_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tro_pkg::t_tro_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tro_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tro_pkg::SIZE_W-1:0]          i_cfg_wdata
);
    import tro_pkg::*;

    localparam int DIV_STAGES = (NODE_W + DIV_BPS - 1) / DIV_BPS;

    // Size registers.
    logic [SIZE_W-1:0] r_x_size;
    logic [SIZE_W-1:0] r_y_size;
    logic [SIZE_W-1:0] r_z_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= SIZE_RESET;
            r_y_size <= SIZE_RESET;
            r_z_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_SIZE: r_x_size <= i_cfg_wdata;
                CFG_Y_SIZE: r_y_size <= i_cfg_wdata;
                CFG_Z_SIZE: r_z_size <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, and sizes saturate at the maximum.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            return SIZE_W'(MAX_DIM);
        end
        return v;
    endfunction

    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;

    assign sx = eff_size(r_x_size);
    assign sy = eff_size(r_y_size);
    assign sz = eff_size(r_z_size);

    // One enable for the whole pipeline: it moves unless the output
    // register holds a result that the consumer is stalling.
    logic       r_out_valid;
    t_tro_out   r_out;
    logic       pipe_en;

    assign pipe_en    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !pipe_en;

    // First division: node number by x size gives x and the plane index.
    logic [LANES-1:0][NODE_W-1:0] div1_num;
    logic                         div1_valid;
    logic [LANES-1:0][NODE_W-1:0] div1_quo;
    logic [LANES-1:0][SIZE_W-1:0] div1_rem;

    assign div1_num[LANE_SRC] = i_in_data.source_node;
    assign div1_num[LANE_DST] = i_in_data.destination_node;

    tro_div #(
        .NUM_W (NODE_W),
        .DEN_W (SIZE_W),
        .BPS   (DIV_BPS),
        .LANES (LANES)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_num   (div1_num),
        .i_den   (sx),
        .o_valid (div1_valid),
        .o_quo   (div1_quo),
        .o_rem   (div1_rem)
    );

    // Second division: plane index by y size gives y and z.
    logic                         div2_valid;
    logic [LANES-1:0][NODE_W-1:0] div2_quo;
    logic [LANES-1:0][SIZE_W-1:0] div2_rem;

    tro_div #(
        .NUM_W (NODE_W),
        .DEN_W (SIZE_W),
        .BPS   (DIV_BPS),
        .LANES (LANES)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (div1_valid),
        .i_num   (div1_quo),
        .i_den   (sy),
        .o_valid (div2_valid),
        .o_quo   (div2_quo),
        .o_rem   (div2_rem)
    );

    // The x coordinates wait alongside the second division.
    logic [LANES-1:0][SIZE_W-1:0] x_coord;

    tro_delay #(
        .W     (LANES * SIZE_W),
        .DEPTH (DIV_STAGES)
    ) u_x_delay (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_data (div1_rem),
        .o_data (x_coord)
    );

    // Final stage: range check and the three dimension offsets.
    logic [OFS_W-1:0] ofs_x;
    logic [OFS_W-1:0] ofs_y;
    logic [OFS_W-1:0] ofs_z;
    logic             id_err;
    t_tro_out         n_out;

    tro_offset u_ofs_x (
        .i_src  (x_coord[LANE_SRC]),
        .i_dst  (x_coord[LANE_DST]),
        .i_size (sx),
        .o_ofs  (ofs_x)
    );

    tro_offset u_ofs_y (
        .i_src  (div2_rem[LANE_SRC]),
        .i_dst  (div2_rem[LANE_DST]),
        .i_size (sy),
        .o_ofs  (ofs_y)
    );

    tro_offset u_ofs_z (
        .i_src  (div2_quo[LANE_SRC][SIZE_W-1:0]),
        .i_dst  (div2_quo[LANE_DST][SIZE_W-1:0]),
        .i_size (sz),
        .o_ofs  (ofs_z)
    );

    // A node is outside the grid exactly when its z quotient reaches z size.
    assign id_err = (div2_quo[LANE_SRC] >= NODE_W'(sz))
                 || (div2_quo[LANE_DST] >= NODE_W'(sz));

    always_comb begin
        n_out = '0;
        n_out.id_error = id_err;
        if (!id_err) begin
            n_out.rel_x = ofs_x;
            n_out.rel_y = ofs_y;
            n_out.rel_z = ofs_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= div2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && div2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The input side only stalls behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // An out-of-grid result carries no offsets.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.id_error) |->
            (o_out_data.rel_x == '0 && o_out_data.rel_y == '0
             && o_out_data.rel_z == '0))
        else $error("offsets not cleared on id error");

    // The shorter way never exceeds half of the dimension size.
    a_half_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.id_error) |->
            (o_out_data.rel_x[SIZE_W-1:0] <= (sx >> 1)
             && o_out_data.rel_y[SIZE_W-1:0] <= (sy >> 1)
             && o_out_data.rel_z[SIZE_W-1:0] <= (sz >> 1)))
        else $error("hop count above half the size");

    // In x, a negative direction always comes with a nonzero hop count.
    a_dir_hops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rel_x[DIRECTION_BIT]) |->
            (o_out_data.rel_x[SIZE_W-1:0] != '0))
        else $error("direction bit set with zero hops");
`endif

endmodule

// ----- hw/rtl/tro_div.sv -----
// Pipelined restoring divider with several lanes sharing one divisor.
module tro_div #(
    parameter int NUM_W = tro_pkg::NODE_W,
    parameter int DEN_W = tro_pkg::SIZE_W,
    parameter int BPS   = tro_pkg::DIV_BPS,
    parameter int LANES = tro_pkg::LANES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_valid,
    output logic [LANES-1:0][NUM_W-1:0] o_quo,
    output logic [LANES-1:0][DEN_W-1:0] o_rem
);
    import tro_pkg::*;

    localparam int STAGES = (NUM_W + BPS - 1) / BPS;

    logic [STAGES-1:0]           r_valid;
    logic [LANES-1:0][NUM_W-1:0] r_num [STAGES];
    logic [LANES-1:0][DEN_W-1:0] r_rem [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                        valid_in;
        logic [LANES-1:0][NUM_W-1:0] num_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][NUM_W-1:0] n_num;
        logic [LANES-1:0][DEN_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign valid_in = i_valid;
            assign num_in   = i_num;
            assign rem_in   = '0;
        end else begin : g_next
            assign valid_in = r_valid[g-1];
            assign num_in   = r_num[g-1];
            assign rem_in   = r_rem[g-1];
        end

        // Each step shifts one dividend bit into the partial remainder and
        // shifts the resulting quotient bit into the vacated low end.
        always_comb begin : p_step
            logic [DEN_W:0]   t;
            logic [NUM_W-1:0] n;
            logic [DEN_W-1:0] r;
            n_num = num_in;
            n_rem = rem_in;
            for (int l = 0; l < LANES; l++) begin
                n = num_in[l];
                r = rem_in[l];
                t = '0;
                for (int k = 0; k < BPS; k++) begin
                    if (g * BPS + k < NUM_W) begin
                        t = {r, n[NUM_W-1]};
                        if (t >= {1'b0, i_den}) begin
                            t = t - {1'b0, i_den};
                            n = {n[NUM_W-2:0], 1'b1};
                        end else begin
                            n = {n[NUM_W-2:0], 1'b0};
                        end
                        r = t[DEN_W-1:0];
                    end
                end
                n_num[l] = n;
                n_rem[l] = r;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g] <= n_num;
                r_rem[g] <= n_rem;
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_quo   = r_num[STAGES-1];
    assign o_rem   = r_rem[STAGES-1];

endmodule

// ----- hw/rtl/tro_delay.sv -----
// Enabled delay line that keeps side data aligned with the divider stages.
module tro_delay #(
    parameter int W     = 2 * tro_pkg::SIZE_W,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);
    import tro_pkg::*;

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ----- hw/rtl/tro_offset.sv -----
// Shortest wrapped offset along one torus dimension.
module tro_offset (
    input  logic [tro_pkg::SIZE_W-1:0] i_src,
    input  logic [tro_pkg::SIZE_W-1:0] i_dst,
    input  logic [tro_pkg::SIZE_W-1:0] i_size,
    output logic [tro_pkg::OFS_W-1:0]  o_ofs
);
    import tro_pkg::*;

    logic [SIZE_W-1:0] fwd;

    // Both coordinates are below the size, so one conditional add wraps.
    always_comb begin
        if (i_dst >= i_src) begin
            fwd = i_dst - i_src;
        end else begin
            fwd = i_dst + i_size - i_src;
        end
        o_ofs = '0;
        if (fwd > (i_size >> 1)) begin
            o_ofs[SIZE_W-1:0]    = i_size - fwd;
            o_ofs[DIRECTION_BIT] = 1'b1;
        end else begin
            o_ofs[SIZE_W-1:0] = fwd;
        end
    end

endmodule

// ----- verif/torus3d_relative_offset_test.sv -----
// Self-checking testbench of the 3D torus relative offset block.
`timescale 1ns / 1ps

module torus3d_relative_offset_test;
    import tro_pkg::*;

    // The pipeline depth of the block: two pipelined dividers of
    // ceil(21 / DIV_BPS) stages each, and one output stage.
    localparam int PIPE_LATENCY = 2 * ((NODE_W + DIV_BPS - 1) / DIV_BPS) + 1;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES = 14;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE = 5;
    localparam int PAUSE_PHASE = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int HALF_DIVISOR = 2;
    localparam int NODE_SPAN = 1 << NODE_W;
    localparam int N_DIRECTED = 23;

    // Index 3 has no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] xs;
        logic [SIZE_W-1:0] ys;
        logic [SIZE_W-1:0] zs;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic              known;
        t_tro_out          result;
    } t_directed_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_tro_in           i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_tro_out          o_out_data;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;

    // Local copy of the three size registers, reset values included.
    logic [SIZE_W-1:0] cur_x_size = SIZE_RESET;
    logic [SIZE_W-1:0] cur_y_size = SIZE_RESET;
    logic [SIZE_W-1:0] cur_z_size = SIZE_RESET;

    // Offsets predicted for accepted transactions, oldest first.
    t_tro_out pending_offsets[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  send_gaps_on = 1'b0;
    int  stall_pct = 0;
    bit  hold_off_request = 1'b0;

    // Directed transactions. The first group runs at the reset sizes, so it
    // also proves that the size registers come out of reset at four.
    // Expected offsets are typed in where they follow from the sizes at a
    // glance; the other rows go through the predictor.
    t_directed_row directed_rows [N_DIRECTED] = '{
        // Same node: nothing to travel.
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd0, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0}},
        // Far corner: each dimension is one hop the negative way.
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd63, 1'b1, {8'h81, 8'h81, 8'h81, 1'b0}},
        // Exactly half way around in x: the tie stays positive.
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd2, 1'b1, {8'h02, 8'h00, 8'h00, 1'b0}},
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd1, 1'b1, {8'h01, 8'h00, 8'h00, 1'b0}},
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd3, 1'b1, {8'h81, 8'h00, 8'h00, 1'b0}},
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd12, 1'b1, {8'h00, 8'h81, 8'h00, 1'b0}},
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd48, 1'b1, {8'h00, 8'h00, 8'h81, 1'b0}},
        // Wrapping forward from the last node to the first.
        '{7'd4, 7'd4, 7'd4, 21'd63, 21'd0, 1'b1, {8'h01, 8'h01, 8'h01, 1'b0}},
        // Node numbers just past the grid, on either side, and all ones.
        '{7'd4, 7'd4, 7'd4, 21'd0, 21'd64, 1'b1, {24'h0, 1'b1}},
        '{7'd4, 7'd4, 7'd4, 21'd64, 21'd0, 1'b1, {24'h0, 1'b1}},
        '{7'd4, 7'd4, 7'd4, 21'h1FFFFF, 21'h1FFFFF, 1'b1, {24'h0, 1'b1}},
        '{7'd4, 7'd4, 7'd4, 21'h155555, 21'h0AAAAA, 1'b1, {24'h0, 1'b1}},
        '{7'd4, 7'd4, 7'd4, 21'd37, 21'd26, 1'b0, '0},
        // Largest torus: the last node is the highest legal number.
        '{7'd127, 7'd127, 7'd127, 21'd0, 21'd2048382, 1'b1, {8'h81, 8'h81, 8'h81, 1'b0}},
        '{7'd127, 7'd127, 7'd127, 21'd0, 21'd2048383, 1'b1, {24'h0, 1'b1}},
        // Odd size: 63 is the last offset that stays positive, 64 flips.
        '{7'd127, 7'd127, 7'd127, 21'd0, 21'd63, 1'b1, {8'h3F, 8'h00, 8'h00, 1'b0}},
        '{7'd127, 7'd127, 7'd127, 21'd0, 21'd64, 1'b1, {8'hBF, 8'h00, 8'h00, 1'b0}},
        '{7'd127, 7'd127, 7'd127, 21'd2048382, 21'd0, 1'b1, {8'h01, 8'h01, 8'h01, 1'b0}},
        '{7'd127, 7'd127, 7'd127, 21'h0AAAAA, 21'h155555, 1'b0, '0},
        // Sizes of zero act as one: a single node, everything else is out.
        '{7'd0, 7'd0, 7'd0, 21'd0, 21'd0, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0}},
        '{7'd0, 7'd0, 7'd0, 21'd0, 21'd1, 1'b1, {24'h0, 1'b1}},
        // A size of one in x keeps that offset at zero; z has size two.
        '{7'd1, 7'd127, 7'd2, 21'd130, 21'd200, 1'b0, '0},
        // Size two: every nonzero offset is a tie and stays positive.
        '{7'd2, 7'd2, 7'd2, 21'd0, 21'd7, 1'b1, {8'h01, 8'h01, 8'h01, 1'b0}}
    };

    torus3d_relative_offset u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor of the offsets.
    // ------------------------------------------------------------------

    // A size register of zero acts as one; anything above the largest
    // dimension saturates (not reachable with seven bits, kept for form).
    function automatic int effective_dim(logic [SIZE_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int grid_total();
        return effective_dim(cur_x_size) * effective_dim(cur_y_size)
            * effective_dim(cur_z_size);
    endfunction

    // Shorter way around one ring; both coordinates lie below the size.
    function automatic logic [OFS_W-1:0] ring_hops(int from, int to, int size);
        int d;
        logic [OFS_W-1:0] hops;
        d = (to + size - from) % size;
        if (d > size / HALF_DIVISOR) begin
            hops = OFS_W'(size - d) & 8'h7F;
            hops[DIRECTION_BIT] = 1'b1;
        end else begin
            hops = OFS_W'(d) & 8'h7F;
        end
        return hops;
    endfunction

    function automatic t_tro_out predict_offsets(t_tro_in req);
        int sx, sy, sz, plane, total, s, d;
        t_tro_out r;
        sx = effective_dim(cur_x_size);
        sy = effective_dim(cur_y_size);
        sz = effective_dim(cur_z_size);
        plane = sx * sy;
        total = plane * sz;
        s = int'(req.source_node);
        d = int'(req.destination_node);
        r = '0;
        if (s >= total || d >= total) begin
            r.id_error = 1'b1;
        end else begin
            r.rel_x = ring_hops(s % sx, d % sx, sx);
            r.rel_y = ring_hops((s % plane) / sx, (d % plane) / sx, sy);
            r.rel_z = ring_hops(s / plane, d / plane, sz);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------

    // Length of an idle or stall burst: mostly short, now and then long.
    function automatic int pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sizes lean toward the edges: zero, one, two and the maximum.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 18) return SIZE_W'(1);
        if (r < 28) return SIZE_W'(2);
        if (r < 43) return SIZE_W'(MAX_DIM);
        return SIZE_W'($urandom_range(1, 127));
    endfunction

    // Most node numbers lie inside the grid; the rest are out of range,
    // raw 21-bit noise, the corner nodes, or a copy of the other node.
    function automatic logic [NODE_W-1:0] pick_node(int total, logic [NODE_W-1:0] other);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return NODE_W'($urandom_range(total, NODE_SPAN - 1));
        if (r < 12) return NODE_W'($urandom);
        if (r < 15) return '0;
        if (r < 18) return NODE_W'(total - 1);
        if (r < 30) return other;
        return NODE_W'($urandom_range(0, total - 1));
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one transaction and returns at the edge that takes it. Valid
    // stays high on return, so back-to-back transactions need no second
    // assignment to it in the same step.
    task automatic send_node_pair(input t_tro_in req, input t_tro_out want);
        int gap;
        gap = 0;
        if (send_gaps_on && $urandom_range(0, 99) < 30) gap = pick_burst();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_offsets.insert(pending_offsets.size(), want);
    endtask

    // Stops offering and waits until every predicted result has come back,
    // then lets the pipeline run empty before anything else happens.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three sizes, preceded by a write to the unused index that
    // must leave them alone. Only called with nothing in flight.
    task automatic program_sizes(input logic [SIZE_W-1:0] xs,
                                 input logic [SIZE_W-1:0] ys,
                                 input logic [SIZE_W-1:0] zs);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_UNUSED_IDX;
        i_cfg_wdata <= SIZE_W'($urandom);
        @(posedge i_clk);
        i_cfg_idx <= CFG_X_SIZE;
        i_cfg_wdata <= xs;
        @(posedge i_clk);
        i_cfg_idx <= CFG_Y_SIZE;
        i_cfg_wdata <= ys;
        @(posedge i_clk);
        i_cfg_idx <= CFG_Z_SIZE;
        i_cfg_wdata <= zs;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_x_size = xs;
        cur_y_size = ys;
        cur_z_size = zs;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request. The
    // hold-off is counted here so that the sender keeps offering meanwhile.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_out_stall
        int hold_left;
        int stall_left;
        if (!i_rst_n) begin
            hold_left = 0;
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_burst() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every delivered transaction is matched against the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_offsets
        t_tro_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_offsets.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("ERROR cycle %0d: result %h with none expected",
                             cycle_count, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_offsets.pop_front();
                if (o_out_data.rel_x !== want.rel_x || o_out_data.rel_y !== want.rel_y
                        || o_out_data.rel_z !== want.rel_z
                        || o_out_data.id_error !== want.id_error) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("ERROR cycle %0d: expected %h %h %h %b, got %h %h %h %b",
                                 cycle_count,
                                 want.rel_x, want.rel_y, want.rel_z, want.id_error,
                                 o_out_data.rel_x, o_out_data.rel_y, o_out_data.rel_z,
                                 o_out_data.id_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random phases, each
    // with its own sizes and its own idling pattern.
    // ------------------------------------------------------------------
    initial begin : run_sequence
        t_tro_in req;
        t_tro_out want;
        int total;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Moderate idling on both sides while the table runs.
        send_gaps_on = 1'b1;
        stall_pct = 20;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].xs != cur_x_size || directed_rows[k].ys != cur_y_size
                    || directed_rows[k].zs != cur_z_size) begin
                wait_for_drain();
                program_sizes(directed_rows[k].xs, directed_rows[k].ys,
                              directed_rows[k].zs);
            end
            req.source_node = directed_rows[k].src;
            req.destination_node = directed_rows[k].dst;
            want = directed_rows[k].known ? directed_rows[k].result : predict_offsets(req);
            send_node_pair(req, want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_drain();
            program_sizes(pick_size(), pick_size(), pick_size());
            total = grid_total();
            // Cycle through: no idling at all, sender gaps only, gaps on
            // both sides, receiver stalls only.
            send_gaps_on = (ph % 4 == 1) || (ph % 4 == 2);
            stall_pct = (ph % 4 >= 2) ? 25 : 0;
            // The hold-off phase sends flat out so the pipeline backs up
            // behind the stalled output and pushes back on the input.
            if (ph == HOLD_PHASE) send_gaps_on = 1'b0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (ph == HOLD_PHASE && i == 20) hold_off_request = 1'b1;
                // Halfway through one phase the sender pauses until every
                // outstanding result is back, then picks up again.
                if (ph == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2) wait_for_drain();
                req.source_node = pick_node(total, NODE_W'($urandom));
                req.destination_node = pick_node(total, req.source_node);
                send_node_pair(req, predict_offsets(req));
            end
        end

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- torus3d_relative_offset.f -----
hw/rtl/tro_pkg.sv
hw/rtl/tro_div.sv
hw/rtl/tro_delay.sv
hw/rtl/tro_offset.sv
hw/rtl/torus3d_relative_offset.sv
verif/torus3d_relative_offset_test.sv
